>>> src/fcit_pkg.sv
package fcit_pkg;

    // Number of credit-limit slots: P, NP, Cpl dedicated, then P, NP, Cpl shared.
    localparam int NUM_SLOTS = 6;
    localparam int SLOT_BITS = 3;

    // Slot code reported when a request writes no slot.
    localparam logic [SLOT_BITS-1:0] NO_SLOT = 3'd6;

    // Offset from a dedicated slot to its shared counterpart.
    localparam logic [SLOT_BITS-1:0] SHARED_OFFSET = 3'd3;

    // Width of the sideband that carries the selector fields.
    localparam int USER_BITS = 5;

    // Width of the fixed (non-credit) part of a result.
    localparam int STATUS_BITS = 11;

    // DLLP kinds.
    typedef enum logic [1:0] {
        KIND_INITFC1  = 2'd0,
        KIND_INITFC2  = 2'd1,
        KIND_UPDATEFC = 2'd2,
        KIND_OTHER    = 2'd3
    } dllp_kind_t;

    // Credit classes.
    typedef enum logic [1:0] {
        CLASS_POSTED     = 2'd0,
        CLASS_NONPOSTED  = 2'd1,
        CLASS_COMPLETION = 2'd2,
        CLASS_OTHER      = 2'd3
    } credit_class_t;

    // Selector fields of one DLLP.
    typedef struct packed {
        credit_class_t credit_class;
        logic          is_shared;
        dllp_kind_t    dllp_kind;
    } fcit_sel_t;

    // Tracker status after one DLLP.
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot_written;
        logic [NUM_SLOTS-1:0] slots_valid;
        logic                 init2_done;
        logic                 init1_done;
    } fcit_status_t;

endpackage

>>> src/flow_control_init_tracker.sv
// Flow-control initialization tracker.
// Input channel (s_*): one decoded flow-control DLLP per request. tuser carries
// the kind, the shared/dedicated flag and the credit class; tdata carries the
// header and data credit limits.
// Output channel (m_*): one result per DLLP, in order: the phase flags, the
// slot valid bits, the slot written (6 for none) and the limits now held in
// that slot (zero when no slot was written).
// The path has one input register, then the slot decode and flag update
// feeding the result register. Throughput is one DLLP per cycle while the
// receiver does not stall; the single slot write and flag compares complete
// in that one stage, so back-to-back requests see each other's updates.
// Reset clears all slot valid bits and both phase flags; stored limits are
// not cleared, since a limit is reported only for the slot just written.
// When the receiver stalls, the result register holds its request and the
// input register fills; s_tready drops only once both stages are occupied.
module flow_control_init_tracker #(
    parameter int HDR_CREDIT_BITS  = 8,
    parameter int DATA_CREDIT_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: hdr_credits, data_credits, zero padding.
    input  logic [((HDR_CREDIT_BITS+DATA_CREDIT_BITS+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0: dllp_kind[1:0], is_shared, credit_class[1:0].
    input  logic [fcit_pkg::USER_BITS-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: init1_done, init2_done, slots_valid[5:0],
    // slot_written[2:0], stored_hdr, stored_data, zero padding.
    output logic [((fcit_pkg::STATUS_BITS+HDR_CREDIT_BITS+DATA_CREDIT_BITS+7)/8)*8-1:0]
                                                   m_tdata
);

    localparam int OUT_BITS = fcit_pkg::STATUS_BITS + HDR_CREDIT_BITS + DATA_CREDIT_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Input stage.
    logic                        in_valid_reg;
    fcit_pkg::fcit_sel_t         in_sel_reg;
    logic [HDR_CREDIT_BITS-1:0]  in_hdr_reg;
    logic [DATA_CREDIT_BITS-1:0] in_data_reg;

    // Result stage.
    logic                        out_valid_reg;
    fcit_pkg::fcit_status_t      out_status_reg;

    fcit_pkg::fcit_status_t      status_next;
    logic [HDR_CREDIT_BITS-1:0]  rd_hdr;
    logic [DATA_CREDIT_BITS-1:0] rd_data;
    logic                        out_free;
    logic                        advance;
    logic                        in_accept;

    // Stage handshakes.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_sel_reg  <= fcit_pkg::fcit_sel_t'(s_tuser);
            in_hdr_reg  <= s_tdata[HDR_CREDIT_BITS-1:0];
            in_data_reg <= s_tdata[HDR_CREDIT_BITS+DATA_CREDIT_BITS-1:HDR_CREDIT_BITS];
        end
    end

    // Slot store and phase tracking.
    fcit_core #(
        .HDR_CREDIT_BITS  (HDR_CREDIT_BITS),
        .DATA_CREDIT_BITS (DATA_CREDIT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (advance),
        .sel          (in_sel_reg),
        .hdr_credits  (in_hdr_reg),
        .data_credits (in_data_reg),
        .status_next  (status_next),
        .rd_slot      (out_status_reg.slot_written),
        .rd_hdr       (rd_hdr),
        .rd_data      (rd_data)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
        end
    end

    // Result packing; limits come from the slot just written.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({rd_data, rd_hdr,
                              out_status_reg.slot_written,
                              out_status_reg.slots_valid,
                              out_status_reg.init2_done,
                              out_status_reg.init1_done});

endmodule

>>> src/fcit_core.sv
module fcit_core #(
    parameter int HDR_CREDIT_BITS  = 8,
    parameter int DATA_CREDIT_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 upd,
    input  fcit_pkg::fcit_sel_t                  sel,
    input  logic [HDR_CREDIT_BITS-1:0]           hdr_credits,
    input  logic [DATA_CREDIT_BITS-1:0]          data_credits,
    output fcit_pkg::fcit_status_t               status_next,
    input  logic [fcit_pkg::SLOT_BITS-1:0]       rd_slot,
    output logic [HDR_CREDIT_BITS-1:0]           rd_hdr,
    output logic [DATA_CREDIT_BITS-1:0]          rd_data
);

    // Stored limits; an entry is only read after it has been written.
    logic [HDR_CREDIT_BITS-1:0]  limit_hdr_reg  [fcit_pkg::NUM_SLOTS];
    logic [DATA_CREDIT_BITS-1:0] limit_data_reg [fcit_pkg::NUM_SLOTS];

    logic [fcit_pkg::NUM_SLOTS-1:0] valid_reg;
    logic [fcit_pkg::NUM_SLOTS-1:0] valid_next;
    logic                           init1_reg;
    logic                           init1_next;
    logic                           init2_reg;
    logic                           init2_next;

    logic                           write_en;
    logic [fcit_pkg::SLOT_BITS-1:0] slot_sel;

    // Slot decode and next tracker state for the request at the input.
    always_comb
    begin
        slot_sel = {1'b0, sel.credit_class}
                 + (sel.is_shared ? fcit_pkg::SHARED_OFFSET : '0);
        write_en = !init1_reg && (sel.credit_class != fcit_pkg::CLASS_OTHER);

        valid_next = valid_reg;
        if (write_en)
        begin
            valid_next = valid_reg
                       | (fcit_pkg::NUM_SLOTS'(1) << slot_sel);
        end

        // The last slot filled sets the first flag; the second flag needs
        // the first one already set before this request.
        init1_next = init1_reg || (&valid_next);
        init2_next = init2_reg
                  || (init1_reg && (sel.dllp_kind == fcit_pkg::KIND_INITFC2));

        status_next.init1_done   = init1_next;
        status_next.init2_done   = init2_next;
        status_next.slots_valid  = valid_next;
        status_next.slot_written = write_en ? slot_sel : fcit_pkg::NO_SLOT;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            init1_reg <= 1'b0;
            init2_reg <= 1'b0;
        end
        else if (upd)
        begin
            valid_reg <= valid_next;
            init1_reg <= init1_next;
            init2_reg <= init2_next;
        end
    end

    // Limit store, at most one slot written per request.
    always_ff @(posedge clk)
    begin
        if (upd && write_en)
        begin
            limit_hdr_reg[slot_sel]  <= hdr_credits;
            limit_data_reg[slot_sel] <= data_credits;
        end
    end

    // Read of the slot reported by the result stage; no slot reads as zero.
    always_comb
    begin
        if (rd_slot < fcit_pkg::NO_SLOT)
        begin
            rd_hdr  = limit_hdr_reg[rd_slot];
            rd_data = limit_data_reg[rd_slot];
        end
        else
        begin
            rd_hdr  = '0;
            rd_data = '0;
        end
    end

    // The second phase never completes ahead of the first.
    a_init2_after_init1: assert property (@(posedge clk) disable iff (!rst_n)
        init2_reg |-> init1_reg)
        else $error("second phase flag set without first phase flag");

    // The first phase flag means every slot holds a limit.
    a_init1_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
        init1_reg |-> (&valid_reg))
        else $error("first phase flag set with an empty slot");

    // Once frozen, no slot is written again.
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        init1_reg |-> !write_en)
        else $error("slot write after limits were frozen");

    // Slot valid bits never clear outside reset.
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("slot valid bit cleared");

endmodule
